/* rtl/core/ecd_pkg.sv */
// Package for the epoch seconds to calendar date converter.
// Holds the field widths, the time constants, the state types and the calendar helpers.
// No dependencies.
`default_nettype none

package ecd_pkg;

  localparam int SEC_W   = 32;
  localparam int YEAR_W  = 12;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;
  localparam int SECF_W  = 6;

  // Serial divider sizing: the remainder holds anything below 86400.
  localparam int REM_W   = 17;
  localparam int QUOT_W  = 16;
  localparam int STEP_W  = 6;
  localparam int DAYS_W  = 16;
  localparam int YLEN_W  = 9;

  localparam logic [REM_W-1:0]  SECS_PER_DAY  = 17'd86400;
  localparam logic [REM_W-1:0]  SECS_PER_HOUR = 17'd3600;
  localparam logic [REM_W-1:0]  SECS_PER_MIN  = 17'd60;
  localparam logic [STEP_W-1:0] DAY_STEPS     = 6'd32;
  localparam logic [STEP_W-1:0] HOUR_STEPS    = 6'd17;
  localparam logic [STEP_W-1:0] MIN_STEPS     = 6'd12;

  localparam logic [YEAR_W-1:0]  FIRST_YEAR     = 12'd1970;
  localparam logic [6:0]         FIRST_YEAR_100 = 7'd70;
  localparam logic [8:0]         FIRST_YEAR_400 = 9'd370;
  localparam logic [YLEN_W-1:0]  DAYS_NORMAL    = 9'd365;
  localparam logic [YLEN_W-1:0]  DAYS_LEAP      = 9'd366;
  localparam logic [MONTH_W-1:0] JANUARY        = 4'd1;
  localparam logic [MONTH_W-1:0] FEBRUARY       = 4'd2;
  localparam logic [MONTH_W-1:0] DECEMBER       = 4'd12;

  typedef enum logic [2:0] {
    T_IDLE,
    T_DAY,
    T_HOUR,
    T_MIN,
    T_JOIN,
    T_SEND
  } top_state_t;

  typedef enum logic [1:0] {
    W_IDLE,
    W_YEAR,
    W_MONTH,
    W_DONE
  } walk_state_t;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
    logic [SEC_W-1:0]  numer;
    logic [REM_W-1:0]  denom;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quot;
    logic [REM_W-1:0]  rem;
  } div_rsp_t;

  typedef struct packed {
    logic               done;
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } walk_rsp_t;

  // Leap test from the year's low bits and its position in the 100 and 400 year cycles.
  function automatic logic is_leap(input logic [1:0] y_lo, input logic [6:0] c100,
                                   input logic [8:0] c400);
    is_leap = (c400 == 9'd0) || ((y_lo == 2'd0) && (c100 != 7'd0));
  endfunction

  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
    logic [DAY_W-1:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    month_days = len;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/ecd_if.sv */
// Valid/ready channel interfaces for the epoch seconds to calendar date converter.
// Depends on ecd_pkg for the field widths.
`default_nettype none

interface ecd_in_if;
  logic                        valid;
  logic                        ready;
  logic [ecd_pkg::SEC_W-1:0]   epoch_seconds;

  modport source (output valid, output epoch_seconds, input ready);
  modport sink   (input valid, input epoch_seconds, output ready);
endinterface

interface ecd_out_if;
  logic                          valid;
  logic                          ready;
  logic [ecd_pkg::YEAR_W-1:0]    year_out;
  logic [ecd_pkg::MONTH_W-1:0]   month_out;
  logic [ecd_pkg::DAY_W-1:0]     day_out;
  logic [ecd_pkg::HOUR_W-1:0]    hour_out;
  logic [ecd_pkg::MIN_W-1:0]     minute_out;
  logic [ecd_pkg::SECF_W-1:0]    second_out;

  modport source (output valid, output year_out, output month_out, output day_out,
                  output hour_out, output minute_out, output second_out, input ready);
  modport sink   (input valid, input year_out, input month_out, input day_out,
                  input hour_out, input minute_out, input second_out, output ready);
endinterface

`default_nettype wire

/* rtl/core/epoch_seconds_to_calendar_date.sv */
// Epoch seconds to Gregorian calendar date converter, top level.
// Depends on ecd_pkg, ecd_if, ecd_serial_div and ecd_date_walk.
//
// Usage: din carries one 32-bit count of seconds since 1970-01-01 00:00:00 per
// transaction; dout carries the matching year, month, day, hour, minute and second.
// Exactly one result leaves for each input, in order.
//
// Operation: the shared serial divider first splits off whole days, one quotient bit a
// cycle. Then the date walker steps one year per cycle and one month per cycle, while
// the same divider takes the hour and then the minute and second. The result
// transaction follows once both are done; for late dates the year walk finishes last.
// One item is in flight at a time: din.ready is high only when the block is idle, so
// the next input is taken in the cycle after the result leaves.
//
// Stall: the result is held in registers with dout.valid high until dout.ready; the
// next input is taken after that. Reset returns to idle with no result pending.
`default_nettype none

module epoch_seconds_to_calendar_date (
  input  wire        clk,
  input  wire        rst,
  ecd_in_if.sink     din,
  ecd_out_if.source  dout
);
  import ecd_pkg::*;

  top_state_t state, state_next;

  div_req_t  div_req;
  div_rsp_t  div_rsp;
  walk_rsp_t walk_rsp;
  logic      walk_start;

  logic [HOUR_W-1:0] hour;
  logic [MIN_W-1:0]  minute;
  logic [SECF_W-1:0] second;

  ecd_serial_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  ecd_date_walk u_walk (
    .clk   (clk),
    .rst   (rst),
    .start (walk_start),
    .days  (div_rsp.quot + 1'b1),
    .rsp   (walk_rsp)
  );

  always_comb begin
    state_next = state;
    case (state)
      T_IDLE:  if (din.valid) state_next = T_DAY;
      T_DAY:   if (div_rsp.done) state_next = T_HOUR;
      T_HOUR:  if (div_rsp.done) state_next = T_MIN;
      T_MIN:   if (div_rsp.done) state_next = T_JOIN;
      T_JOIN:  if (walk_rsp.done) state_next = T_SEND;
      T_SEND:  if (dout.ready) state_next = T_IDLE;
      default: state_next = T_IDLE;
    endcase
  end

  always_comb begin
    din.ready     = (state == T_IDLE);
    dout.valid    = (state == T_SEND);
    walk_start    = (state == T_DAY) && div_rsp.done;
    div_req.start = 1'b0;
    div_req.steps = DAY_STEPS;
    div_req.numer = din.epoch_seconds;
    div_req.denom = SECS_PER_DAY;
    case (state)
      T_IDLE: begin
        div_req.start = din.valid;
      end
      T_DAY: begin
        // Seconds of day, left-aligned for a 17-bit division by 3600.
        div_req.start = div_rsp.done;
        div_req.steps = HOUR_STEPS;
        div_req.numer = {div_rsp.rem, {(SEC_W-REM_W){1'b0}}};
        div_req.denom = SECS_PER_HOUR;
      end
      T_HOUR: begin
        // Seconds of hour stay below 4096, so 12 bits are divided by 60.
        div_req.start = div_rsp.done;
        div_req.steps = MIN_STEPS;
        div_req.numer = {div_rsp.rem[11:0], {(SEC_W-12){1'b0}}};
        div_req.denom = SECS_PER_MIN;
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == T_HOUR) && div_rsp.done) begin
      hour <= div_rsp.quot[HOUR_W-1:0];
    end
    if ((state == T_MIN) && div_rsp.done) begin
      minute <= div_rsp.quot[MIN_W-1:0];
      second <= div_rsp.rem[SECF_W-1:0];
    end
  end

  // The walker holds its result until the next start, so it drives the output directly.
  assign dout.year_out   = walk_rsp.year;
  assign dout.month_out  = walk_rsp.month;
  assign dout.day_out    = walk_rsp.day;
  assign dout.hour_out   = hour;
  assign dout.minute_out = minute;
  assign dout.second_out = second;

endmodule

`default_nettype wire

/* rtl/core/ecd_serial_div.sv */
// Restoring divider that retires one quotient bit per cycle.
// The numerator arrives left-aligned; steps gives how many of its bits are used.
// Depends on ecd_pkg.
`default_nettype none

module ecd_serial_div (
  input  wire                    clk,
  input  wire                    rst,
  input  wire ecd_pkg::div_req_t req,
  output ecd_pkg::div_rsp_t      rsp
);
  import ecd_pkg::*;

  logic [SEC_W-1:0]  numer_sr;
  logic [REM_W-1:0]  rem;
  logic [REM_W-1:0]  denom;
  logic [QUOT_W-1:0] quot;
  logic [STEP_W-1:0] cnt;
  logic              busy;
  logic              done;

  logic [REM_W:0]    trial;
  logic [REM_W:0]    diff;
  logic              fits;

  assign trial = {rem, numer_sr[SEC_W-1]};
  assign diff  = trial - {1'b0, denom};
  assign fits  = (trial >= {1'b0, denom});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.steps;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      numer_sr <= req.numer;
      denom    <= req.denom;
      rem      <= '0;
      quot     <= '0;
    end else if (busy) begin
      numer_sr <= {numer_sr[SEC_W-2:0], 1'b0};
      // The remainder stays below the divisor, so the low bits always hold it.
      rem      <= fits ? diff[REM_W-1:0] : trial[REM_W-1:0];
      quot     <= {quot[QUOT_W-2:0], fits};
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;
  assign rsp.rem  = rem;

endmodule

`default_nettype wire

/* rtl/core/ecd_date_walk.sv */
// Steps whole years off a day number from 1970, then whole months, one per cycle.
// Leap years are tracked with running positions in the 100 and 400 year cycles.
// Depends on ecd_pkg.
`default_nettype none

module ecd_date_walk (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          start,
  input  wire [ecd_pkg::DAYS_W-1:0]    days,
  output ecd_pkg::walk_rsp_t           rsp
);
  import ecd_pkg::*;

  walk_state_t state, state_next;

  logic [DAYS_W-1:0]  dleft;
  logic [YEAR_W-1:0]  year;
  logic [6:0]         c100;
  logic [8:0]         c400;
  logic [YLEN_W-1:0]  ylen;
  logic [MONTH_W-1:0] month;

  logic [YEAR_W-1:0]  year_next;
  logic [6:0]         c100_next;
  logic [8:0]         c400_next;
  logic [DAY_W-1:0]   mlen;
  logic               year_more;
  logic               month_fits;
  logic               load;

  assign year_next  = year + 1'b1;
  assign c100_next  = (c100 == 7'd99)  ? 7'd0 : c100 + 1'b1;
  assign c400_next  = (c400 == 9'd399) ? 9'd0 : c400 + 1'b1;
  assign mlen       = month_days(month, is_leap(year[1:0], c100, c400));
  assign year_more  = (dleft > {{(DAYS_W-YLEN_W){1'b0}}, ylen});
  assign month_fits = (dleft <= {{(DAYS_W-DAY_W){1'b0}}, mlen});
  assign load       = start && ((state == W_IDLE) || (state == W_DONE));

  always_comb begin
    state_next = state;
    case (state)
      W_IDLE:  if (start) state_next = W_YEAR;
      W_YEAR:  if (!year_more) state_next = W_MONTH;
      W_MONTH: if (month_fits || (month == DECEMBER)) state_next = W_DONE;
      W_DONE:  if (start) state_next = W_YEAR;
      default: state_next = W_IDLE;
    endcase
  end

  always_comb begin
    rsp.done  = (state == W_DONE);
    rsp.year  = year;
    rsp.month = month;
    rsp.day   = dleft[DAY_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= W_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dleft <= days;
      year  <= FIRST_YEAR;
      c100  <= FIRST_YEAR_100;
      c400  <= FIRST_YEAR_400;
      ylen  <= DAYS_NORMAL;
      month <= JANUARY;
    end else if ((state == W_YEAR) && year_more) begin
      dleft <= dleft - {{(DAYS_W-YLEN_W){1'b0}}, ylen};
      year  <= year_next;
      c100  <= c100_next;
      c400  <= c400_next;
      ylen  <= is_leap(year_next[1:0], c100_next, c400_next) ? DAYS_LEAP : DAYS_NORMAL;
    end else if ((state == W_MONTH) && !month_fits) begin
      // December that does not fit cannot happen for a valid day count; it still ends here.
      dleft <= dleft - {{(DAYS_W-DAY_W){1'b0}}, mlen};
      if (month != DECEMBER) begin
        month <= month + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/ecd_checker.sv */
// Port-level checks for the epoch seconds to calendar date converter.
// Bound to epoch_seconds_to_calendar_date; depends on ecd_pkg for widths.
`default_nettype none

module ecd_checker (
  input wire                          clk,
  input wire                          rst,
  input wire                          in_valid,
  input wire                          in_ready,
  input wire                          out_valid,
  input wire                          out_ready,
  input wire [ecd_pkg::YEAR_W-1:0]    year_out,
  input wire [ecd_pkg::MONTH_W-1:0]   month_out,
  input wire [ecd_pkg::DAY_W-1:0]     day_out,
  input wire [ecd_pkg::HOUR_W-1:0]    hour_out,
  input wire [ecd_pkg::MIN_W-1:0]     minute_out,
  input wire [ecd_pkg::SECF_W-1:0]    second_out
);

  // One item in flight: taking an input closes the input side.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while a conversion is in flight");

  // No result is offered while the block is waiting for input.
  a_no_result_when_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid)
    else $error("result offered while idle");

  // Exactly one result per input: a taken result is not offered again.
  a_single_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready) |=> !out_valid)
    else $error("result repeated");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid &&
      $stable({year_out, month_out, day_out, hour_out, minute_out, second_out})))
    else $error("stalled result changed");

  a_fields_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (month_out >= 4'd1 && month_out <= 4'd12 && day_out >= 5'd1 &&
                   hour_out <= 5'd23 && minute_out <= 6'd59 && second_out <= 6'd59 &&
                   year_out >= 12'd1970 && year_out <= 12'd2106))
    else $error("result field out of range");

endmodule

bind epoch_seconds_to_calendar_date ecd_checker u_ecd_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (din.valid),
  .in_ready   (din.ready),
  .out_valid  (dout.valid),
  .out_ready  (dout.ready),
  .year_out   (dout.year_out),
  .month_out  (dout.month_out),
  .day_out    (dout.day_out),
  .hour_out   (dout.hour_out),
  .minute_out (dout.minute_out),
  .second_out (dout.second_out)
);

`default_nettype wire
